// ===== design/bcmd_pkg.sv =====
// Shared types, codes and helper functions for the binary clock menu/display unit.
// No dependencies; used by the interfaces' users, bcmd_step and the top level.
package bcmd_pkg;

  // Menu mode, one-hot. CONFIRM lives for one pass only and is never stored.
  typedef enum logic [5:0] {
    MODE_CLOCK   = 6'b000001,
    MODE_HOURS   = 6'b000010,
    MODE_MINUTES = 6'b000100,
    MODE_FORMAT  = 6'b001000,
    MODE_BRIGHT  = 6'b010000,
    MODE_CONFIRM = 6'b100000
  } mode_e;

  // Mode codes as seen on the result word
  localparam logic [2:0] MS_CLOCK   = 3'd0;
  localparam logic [2:0] MS_HOURS   = 3'd1;
  localparam logic [2:0] MS_MINUTES = 3'd2;
  localparam logic [2:0] MS_FORMAT  = 3'd3;
  localparam logic [2:0] MS_BRIGHT  = 3'd4;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [1:0] LEVEL_RST  = 2'd2;

  // Number of display columns
  localparam int unsigned COLS = 6;

  // One input word
  typedef struct packed {
    logic       menu_pressed;
    logic       up_pressed;
    logic       down_pressed;
    logic [4:0] rtc_hours;
    logic [5:0] rtc_minutes;
    logic [5:0] rtc_seconds;
  } in_word_t;

  // Architectural state carried from pass to pass
  typedef struct packed {
    mode_e                 mode;
    logic [4:0]            held_hours;
    logic [5:0]            held_minutes;
    logic [1:0]            level;
    logic                  fmt_24h;
    logic [COLS-1:0][7:0]  cols;
  } state_t;

  // Confirm request toward the output word
  typedef struct packed {
    logic       commit;
    logic [4:0] hours;
    logic [5:0] minutes;
  } commit_t;

  // BCD digit to column pattern, read from the top of the column
  function automatic logic [7:0] digit_pat(logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h00;
      4'd1:    p = 8'h40;
      4'd2:    p = 8'h20;
      4'd3:    p = 8'h60;
      4'd4:    p = 8'h10;
      4'd5:    p = 8'h50;
      4'd6:    p = 8'h30;
      4'd7:    p = 8'h70;
      4'd8:    p = 8'h08;
      4'd9:    p = 8'h48;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Tens digit of 0..63 by reciprocal multiply: (v*13)>>7
  function automatic logic [2:0] tens_of(logic [5:0] v);
    logic [9:0] p;
    p = {4'b0, v} * 10'd13;
    return p[9:7];
  endfunction

  // Returns {tens pattern, ones pattern} for a value 0..63
  function automatic logic [15:0] pair_cols(logic [5:0] v);
    logic [2:0] t;
    logic [5:0] t10;
    logic [5:0] o;
    t   = tens_of(v);
    t10 = {3'b0, t} * 6'd10;
    o   = v - t10;
    return {digit_pat({1'b0, t}), digit_pat(o[3:0])};
  endfunction

  // 12-hour form of a 24-hour value: ((h + 11) mod 12) + 1, h up to 31
  function automatic logic [4:0] hour12(logic [4:0] h);
    logic [5:0] t;
    t = {1'b0, h} + 6'd11;
    if (t >= 6'd36) begin
      t = t - 6'd36;
    end else if (t >= 6'd24) begin
      t = t - 6'd24;
    end else if (t >= 6'd12) begin
      t = t - 6'd12;
    end
    return t[4:0] + 5'd1;
  endfunction

  // Stored mode to result code
  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    case (m)
      MODE_CLOCK:   c = MS_CLOCK;
      MODE_HOURS:   c = MS_HOURS;
      MODE_MINUTES: c = MS_MINUTES;
      MODE_FORMAT:  c = MS_FORMAT;
      MODE_BRIGHT:  c = MS_BRIGHT;
      default:      c = MS_CLOCK;
    endcase
    return c;
  endfunction

endpackage

// ===== design/bcmd_if.sv =====
// Valid/ready channel interfaces for the binary clock menu/display unit.
// Input channel carries button levels and clock time; output channel the display word.
interface bcmd_in_if;
  logic       valid;
  logic       ready;
  logic       menu_pressed;
  logic       up_pressed;
  logic       down_pressed;
  logic [4:0] rtc_hours;
  logic [5:0] rtc_minutes;
  logic [5:0] rtc_seconds;

  modport source (
    output valid, menu_pressed, up_pressed, down_pressed,
           rtc_hours, rtc_minutes, rtc_seconds,
    input  ready
  );
  modport sink (
    input  valid, menu_pressed, up_pressed, down_pressed,
           rtc_hours, rtc_minutes, rtc_seconds,
    output ready
  );
endinterface

interface bcmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] col_seconds_ones;
  logic [7:0] col_seconds_tens;
  logic [7:0] col_minutes_ones;
  logic [7:0] col_minutes_tens;
  logic [7:0] col_hours_ones;
  logic [7:0] col_hours_tens;
  logic [1:0] intensity;
  logic [2:0] menu_state;
  logic       commit;
  logic [4:0] commit_hours;
  logic [5:0] commit_minutes;
  logic       hour_format_24;

  modport source (
    output valid, col_seconds_ones, col_seconds_tens, col_minutes_ones,
           col_minutes_tens, col_hours_ones, col_hours_tens, intensity,
           menu_state, commit, commit_hours, commit_minutes, hour_format_24,
    input  ready
  );
  modport sink (
    input  valid, col_seconds_ones, col_seconds_tens, col_minutes_ones,
           col_minutes_tens, col_hours_ones, col_hours_tens, intensity,
           menu_state, commit, commit_hours, commit_minutes, hour_format_24,
    output ready
  );
endinterface

// ===== design/binary_clock_menu_display_unit.sv =====
// Top level of the binary clock menu/display unit: input register, pass logic, result register.
// Depends on bcmd_pkg, bcmd_if (bcmd_in_if, bcmd_out_if) and bcmd_step.
//
// Usage:
//   in_i carries one word per pass of the control loop: the three button levels
//   and the clock time. out_o returns one word per input word: six LED column
//   patterns, intensity, menu mode, the confirm request and the 12/24 flag.
//   Both channels are valid/ready; a word moves when valid and ready are high.
// Path: an accepted word enters the input register, then its result loads the result register.
// Throughput: one word per cycle unless out_o.ready stalls the result. The input register frees
//   whenever the result register is empty or being taken, so words stream back to back.
// Stall: while out_o.ready is low the result holds; one more input word is
//   taken into the input register, then in_i.ready drops.
// Reset: clock mode, held time 0:00, intensity 2, 24-hour form, blank columns,
//   both registers empty. The state registers double as the result word.
module binary_clock_menu_display_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  bcmd_in_if.sink          in_i,
  bcmd_out_if.source       out_o
);
  import bcmd_pkg::*;

  // Input register
  logic     s1_valid_q;
  in_word_t s1_word_q;
  in_word_t in_word;
  logic     in_fire;
  logic     s1_fire;
  logic     out_free;

  // State / result register
  state_t   st_q;
  state_t   st_d;
  commit_t  cmt_q;
  commit_t  cmt_d;
  logic     out_valid_q;

  assign in_word = '{menu_pressed: in_i.menu_pressed, up_pressed: in_i.up_pressed,
                     down_pressed: in_i.down_pressed, rtc_hours: in_i.rtc_hours,
                     rtc_minutes: in_i.rtc_minutes, rtc_seconds: in_i.rtc_seconds};

  // Handshake control
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Payload of the input register, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= in_word;
    end
  end

  // Pass logic
  bcmd_step u_step (
    .st_i   (st_q),
    .word_i (s1_word_q),
    .st_o   (st_d),
    .cmt_o  (cmt_d)
  );

  // State and result register, loaded once per pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode         <= MODE_CLOCK;
      st_q.held_hours   <= '0;
      st_q.held_minutes <= '0;
      st_q.level        <= LEVEL_RST;
      st_q.fmt_24h      <= 1'b1;
      st_q.cols         <= '0;
      cmt_q             <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      if (s1_fire) begin
        st_q  <= st_d;
        cmt_q <= cmt_d;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Result word
  assign out_o.valid            = out_valid_q;
  assign out_o.col_seconds_ones = st_q.cols[0];
  assign out_o.col_seconds_tens = st_q.cols[1];
  assign out_o.col_minutes_ones = st_q.cols[2];
  assign out_o.col_minutes_tens = st_q.cols[3];
  assign out_o.col_hours_ones   = st_q.cols[4];
  assign out_o.col_hours_tens   = st_q.cols[5];
  assign out_o.intensity        = st_q.level;
  assign out_o.menu_state       = mode_code(st_q.mode);
  assign out_o.commit           = cmt_q.commit;
  assign out_o.commit_hours     = cmt_q.hours;
  assign out_o.commit_minutes   = cmt_q.minutes;
  assign out_o.hour_format_24   = st_q.fmt_24h;

  // Checks
  a_commit_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmt_q.commit |-> st_q.mode == MODE_CLOCK)
    else $error("confirm left the mode outside clock");

  a_commit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmt_q.commit |-> (cmt_q.hours == 5'd0 && cmt_q.minutes == 6'd0))
    else $error("commit time nonzero without confirm");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> ($stable(st_q) && $stable(cmt_q)))
    else $error("state changed without a pass");

  a_pass_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("pass did not produce a result word");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !s1_fire)
    else $error("stalled result overwritten");

endmodule

// ===== design/bcmd_step.sv =====
// Next-state logic of one control pass: menu advance, set modes, column patterns.
// Depends on bcmd_pkg.
module bcmd_step (
  input  bcmd_pkg::state_t   st_i,
  input  bcmd_pkg::in_word_t word_i,
  output bcmd_pkg::state_t   st_o,
  output bcmd_pkg::commit_t  cmt_o
);
  import bcmd_pkg::*;

  mode_e      mode_eff;
  logic [4:0] hrs;
  logic [5:0] mins;
  logic [4:0] shown;
  logic [1:0] lvl;
  logic [7:0] bar;

  // Mode after a possible menu press
  always_comb begin
    mode_eff = st_i.mode;
    if (word_i.menu_pressed) begin
      case (st_i.mode)
        MODE_CLOCK:   mode_eff = MODE_HOURS;
        MODE_HOURS:   mode_eff = MODE_MINUTES;
        MODE_MINUTES: mode_eff = MODE_FORMAT;
        MODE_FORMAT:  mode_eff = MODE_BRIGHT;
        MODE_BRIGHT:  mode_eff = MODE_CONFIRM;
        default:      mode_eff = MODE_CLOCK;
      endcase
    end
  end

  // Set-mode arithmetic: up first, then down
  always_comb begin
    hrs = st_i.held_hours;
    if (word_i.up_pressed) begin
      hrs = (hrs >= HOUR_MAX) ? 5'd0 : hrs + 5'd1;
    end
    if (word_i.down_pressed) begin
      hrs = (hrs == 5'd0) ? HOUR_MAX : hrs - 5'd1;
    end

    mins = st_i.held_minutes;
    if (word_i.up_pressed) begin
      mins = (mins >= MINUTE_MAX) ? 6'd0 : mins + 6'd1;
    end
    if (word_i.down_pressed) begin
      mins = (mins == 6'd0) ? MINUTE_MAX : mins - 6'd1;
    end

    lvl = st_i.level + {1'b0, word_i.up_pressed} - {1'b0, word_i.down_pressed};

    shown = st_i.fmt_24h ? word_i.rtc_hours : hour12(word_i.rtc_hours);
  end

  // Brightness bar graph
  always_comb begin
    case (lvl)
      2'd0:    bar = 8'h40;
      2'd1:    bar = 8'h60;
      2'd2:    bar = 8'h70;
      default: bar = 8'h78;
    endcase
  end

  // Per-mode update of state and columns
  always_comb begin
    st_o        = st_i;
    st_o.mode   = mode_eff;
    cmt_o       = '0;
    case (mode_eff)
      MODE_CLOCK: begin
        st_o.held_hours   = word_i.rtc_hours;
        st_o.held_minutes = word_i.rtc_minutes;
        st_o.cols[1:0]    = pair_cols(word_i.rtc_seconds);
        st_o.cols[3:2]    = pair_cols(word_i.rtc_minutes);
        st_o.cols[5:4]    = pair_cols({1'b0, shown});
      end
      MODE_HOURS: begin
        st_o.held_hours = hrs;
        st_o.cols[3:0]  = '0;
        st_o.cols[5:4]  = pair_cols({1'b0, hrs});
      end
      MODE_MINUTES: begin
        st_o.held_minutes = mins;
        st_o.cols[1:0]    = '0;
        st_o.cols[5:4]    = '0;
        st_o.cols[3:2]    = pair_cols(mins);
      end
      MODE_FORMAT: begin
        st_o.fmt_24h   = st_i.fmt_24h ^ word_i.up_pressed ^ word_i.down_pressed;
        st_o.cols[3:0] = '0;
        st_o.cols[5:4] = st_o.fmt_24h ? pair_cols(6'd24) : pair_cols(6'd12);
      end
      MODE_BRIGHT: begin
        st_o.level   = lvl;
        st_o.cols[0] = 8'h78 & bar;
        st_o.cols[1] = 8'h70 & bar;
        st_o.cols[2] = 8'h60 & bar;
        st_o.cols[3] = 8'h40 & bar;
        st_o.cols[4] = '0;
        st_o.cols[5] = '0;
      end
      default: begin
        // confirm: columns hold, request the clock write, back to clock mode
        st_o.mode     = MODE_CLOCK;
        cmt_o.commit  = 1'b1;
        cmt_o.hours   = st_i.held_hours;
        cmt_o.minutes = st_i.held_minutes;
      end
    endcase
  end

endmodule
